// ----- rtl/tt_pkg.sv -----
// ----------------------------------------------------------------------------
// tt_pkg
// Shared types and constants for the transposition table: entry layout,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int unsigned INDEX_BITS_DEFAULT     = 16;
    localparam logic [14:0] MATE_THRESHOLD_RESET   = 15'd30000;

    // Input operation codes
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_PROBE  = 1'b1;

    // Bound flag codes
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    // One table entry, 106 bits
    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [15:0]        move;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ADJUST,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic read_en;
        logic adjust_en;
        logic commit_record;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_probe;
        logic out_room;
    } status_t;

endpackage

// ----- rtl/tt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tt_ctrl
// Sequencer for the transposition table: clearing pass after reset, then
// capture, table read, score adjust and commit or result load of one word at a time.
// ----------------------------------------------------------------------------
module tt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tt_pkg::status_t status,
    output tt_pkg::cmd_t    cmd
);

    tt_pkg::state_t state_reg;
    tt_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            tt_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = tt_pkg::ST_IDLE;
                end
            end
            tt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tt_pkg::ST_READ;
                end
            end
            tt_pkg::ST_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = tt_pkg::ST_ADJUST;
            end
            tt_pkg::ST_ADJUST:
            begin
                cmd.adjust_en = 1'b1;
                state_next    = tt_pkg::ST_FINISH;
            end
            tt_pkg::ST_FINISH:
            begin
                if (!status.is_probe)
                begin
                    cmd.commit_record = 1'b1;
                    state_next        = tt_pkg::ST_IDLE;
                end
                else if (status.out_room)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tt_datapath.sv -----
// ----------------------------------------------------------------------------
// tt_datapath
// Entry memory, input capture, mate score adjust, replacement and probe
// evaluation, output register and the mate threshold register.
// ----------------------------------------------------------------------------
module tt_datapath #(
    parameter int unsigned INDEX_BITS = tt_pkg::INDEX_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tt_pkg::cmd_t       cmd,
    output tt_pkg::status_t    status,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [14:0]        cfg_data,
    input  logic               kind,
    input  logic [63:0]        position_key,
    input  logic [7:0]         root_depth,
    input  logic [7:0]         remaining_depth,
    input  logic signed [15:0] score_in,
    input  logic [1:0]         bound_kind,
    input  logic [15:0]        best_move,
    input  logic signed [15:0] window_low,
    input  logic signed [15:0] window_high,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] score_out,
    output logic               score_valid,
    output logic [15:0]        move_out,
    output logic               key_hit
);

    localparam longint unsigned DEPTH = longint'(1) << INDEX_BITS;

    // Saturating mate-distance adjust; record moves away from root, probe back
    function automatic logic signed [15:0] mate_adjust(
        input logic signed [15:0] s,
        input logic signed [8:0]  d,
        input logic               is_probe,
        input logic [14:0]        thr
    );
        logic signed [16:0] s_w;
        logic signed [16:0] thr_w;
        logic signed [17:0] sum;
        logic               pos;
        logic               neg;
        s_w   = {s[15], s};
        thr_w = {2'b00, thr};
        pos   = s_w > thr_w;
        neg   = s_w < -thr_w;
        if ((pos && !is_probe) || (neg && is_probe))
        begin
            sum = {{2{s[15]}}, s} + {{9{d[8]}}, d};
        end
        else
        begin
            sum = {{2{s[15]}}, s} - {{9{d[8]}}, d};
        end
        if (!(pos || neg))
        begin
            return s;
        end
        else if (sum > 18'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (sum < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return sum[15:0];
    endfunction

    tt_pkg::entry_t mem_array [DEPTH];

    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic [14:0]           thr_reg;

    logic                  kind_reg;
    logic [63:0]           key_reg;
    logic [7:0]            rem_reg;
    logic signed [8:0]     dist_reg;
    logic signed [15:0]    score_reg;
    logic [1:0]            bound_reg;
    logic [15:0]           move_reg;
    logic signed [15:0]    alpha_reg;
    logic signed [15:0]    beta_reg;

    tt_pkg::entry_t        rd_reg;
    logic signed [15:0]    adj_reg;
    logic                  hit_reg;
    logic                  depth_ok_reg;

    logic                  out_valid_reg;
    logic signed [15:0]    score_out_reg;
    logic                  score_valid_reg;
    logic [15:0]           move_out_reg;
    logic                  key_hit_reg;

    logic [INDEX_BITS-1:0] idx;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    tt_pkg::entry_t        wr_data;
    logic                  res_valid;
    logic signed [15:0]    res_score;

    assign idx = key_reg[INDEX_BITS-1:0];

    // Step the clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Hold the mate threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tt_pkg::MATE_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            key_reg   <= position_key;
            rem_reg   <= remaining_depth;
            dist_reg  <= $signed({1'b0, root_depth}) - $signed({1'b0, remaining_depth});
            score_reg <= score_in;
            bound_reg <= bound_kind;
            move_reg  <= best_move;
            alpha_reg <= window_low;
            beta_reg  <= window_high;
        end
    end

    // Select the memory write: clearing pass or record commit
    always_comb
    begin
        wr_data = '0;
        if (cmd.clear_en)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
        end
        else
        begin
            wr_en         = cmd.commit_record && depth_ok_reg;
            wr_addr       = idx;
            wr_data.key   = key_reg;
            wr_data.score = adj_reg;
            wr_data.depth = rem_reg;
            wr_data.flag  = bound_reg;
            wr_data.move  = move_reg;
        end
    end

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (cmd.read_en)
        begin
            rd_reg <= mem_array[idx];
        end
    end

    // Adjust the score, compare key and depth
    always_ff @(posedge clk)
    begin
        if (cmd.adjust_en)
        begin
            adj_reg <= mate_adjust(kind_reg ? rd_reg.score : score_reg,
                                   dist_reg, kind_reg, thr_reg);
            hit_reg <= rd_reg.key == key_reg;
            depth_ok_reg <= kind_reg ? (rd_reg.depth >= rem_reg)
                                     : (rem_reg >= rd_reg.depth);
        end
    end

    // Apply the bound rules to a probe
    always_comb
    begin
        res_valid = 1'b0;
        res_score = '0;
        if (hit_reg && depth_ok_reg)
        begin
            priority if (rd_reg.flag == tt_pkg::BOUND_EXACT)
            begin
                res_valid = 1'b1;
                res_score = adj_reg;
            end
            else if (rd_reg.flag == tt_pkg::BOUND_UPPER && adj_reg <= alpha_reg)
            begin
                res_valid = 1'b1;
                res_score = alpha_reg;
            end
            else if (rd_reg.flag == tt_pkg::BOUND_LOWER && adj_reg >= beta_reg)
            begin
                res_valid = 1'b1;
                res_score = beta_reg;
            end
            else
            begin
                res_valid = 1'b0;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            score_out_reg   <= res_score;
            score_valid_reg <= res_valid;
            move_out_reg    <= hit_reg ? rd_reg.move : 16'd0;
            key_hit_reg     <= hit_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign score_out   = score_out_reg;
    assign score_valid = score_valid_reg;
    assign move_out    = move_out_reg;
    assign key_hit     = key_hit_reg;

    assign status.clear_last = &clr_addr_reg;
    assign status.is_probe   = kind_reg;
    assign status.out_room   = !out_valid_reg || !out_stall;

endmodule

// ----- rtl/transposition_table.sv -----
// ----------------------------------------------------------------------------
// transposition_table
// Direct-mapped search-result table with depth-preferred replacement.
// ----------------------------------------------------------------------------
// After reset the table runs a clearing pass over all 2^INDEX_BITS entries
// (65536 at the default) that zeroes every entry; in_stall stays high during
// it, while the mate_threshold register can be written at any time. Each word
// then passes through the single-port entry memory in these steps: capture,
// registered read, score adjust with key and depth compare, then either the
// depth-gated write of a record or the load of a probe result into the output
// register. A probe holds in that last step while an earlier result still
// waits in the output register under out_stall.
// A record returns nothing; a probe returns one word. A pending result can
// sit in the output register while the next word is captured.
module transposition_table #(
    parameter int unsigned INDEX_BITS = tt_pkg::INDEX_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [63:0]        position_key,
    input  logic [7:0]         root_depth,
    input  logic [7:0]         remaining_depth,
    input  logic signed [15:0] score_in,
    input  logic [1:0]         bound_kind,
    input  logic [15:0]        best_move,
    input  logic signed [15:0] window_low,
    input  logic signed [15:0] window_high,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] score_out,
    output logic               score_valid,
    output logic [15:0]        move_out,
    output logic               key_hit
);

    tt_pkg::cmd_t    cmd;
    tt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tt_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .kind            (kind),
        .position_key    (position_key),
        .root_depth      (root_depth),
        .remaining_depth (remaining_depth),
        .score_in        (score_in),
        .bound_kind      (bound_kind),
        .best_move       (best_move),
        .window_low      (window_low),
        .window_high     (window_high),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .score_out       (score_out),
        .score_valid     (score_valid),
        .move_out        (move_out),
        .key_hit         (key_hit)
    );

endmodule

// ----- rtl/tt_checker.sv -----
// ----------------------------------------------------------------------------
// tt_checker
// Port-level checks for the transposition table, bound to the top level.
// ----------------------------------------------------------------------------
module tt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] score_out,
    input logic               score_valid,
    input logic [15:0]        move_out,
    input logic               key_hit
);

    // A stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // An unusable score reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !score_valid |-> score_out == 16'sd0)
        else $error("score_out nonzero without score_valid");

    // A key miss carries no move and no score
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_hit |-> move_out == 16'd0 && !score_valid)
        else $error("miss reported a move or a score");

    // Clearing pass holds off input right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input accepted during clearing pass");

endmodule

bind transposition_table tt_checker u_tt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .score_out   (score_out),
    .score_valid (score_valid),
    .move_out    (move_out),
    .key_hit     (key_hit)
);

// ----- test/tb_transposition_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transposition_table
// Self-checking bench for the transposition table. A shadow copy of the entry
// store predicts every probe answer in acceptance order. The bench runs a
// directed pass over mate adjustment, saturation, bound rules and replacement,
// then random phases over several mate thresholds and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_transposition_table;

    localparam int IDX             = tt_pkg::INDEX_BITS_DEFAULT;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WORDS_PER_PHASE = 235;
    localparam int POOL_SIZE       = 24;
    localparam int PHASES          = 8;

    typedef struct packed {
        logic               kind;
        logic [63:0]        key;
        logic [7:0]         root;
        logic [7:0]         rem;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } search_word_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic               valid;
        logic [15:0]        move;
        logic               hit;
    } probe_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data  = '0;

    logic         in_valid     = 1'b0;
    logic         in_stall;
    search_word_t offered_word = '0;
    logic         out_valid;
    logic         out_stall    = 1'b0;

    logic               kind;
    logic [63:0]        position_key;
    logic [7:0]         root_depth;
    logic [7:0]         remaining_depth;
    logic signed [15:0] score_in;
    logic [1:0]         bound_kind;
    logic [15:0]        best_move;
    logic signed [15:0] window_low;
    logic signed [15:0] window_high;
    logic signed [15:0] score_out;
    logic               score_valid;
    logic [15:0]        move_out;
    logic               key_hit;

    // Shadow store and register copy
    tt_pkg::entry_t shadow_table [int];
    int             mate_limit = 30000;

    search_word_t  pending_words [$];
    probe_result_t probe_results_due [$];
    logic [63:0]   key_pool [POOL_SIZE];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    bit hold_phase      = 1'b0;
    bit hold_done       = 1'b0;
    int hold_count      = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    assign kind            = offered_word.kind;
    assign position_key    = offered_word.key;
    assign root_depth      = offered_word.root;
    assign remaining_depth = offered_word.rem;
    assign score_in        = offered_word.score;
    assign bound_kind      = offered_word.bound;
    assign best_move       = offered_word.move;
    assign window_low      = offered_word.alpha;
    assign window_high     = offered_word.beta;

    transposition_table i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .position_key    (position_key),
        .root_depth      (root_depth),
        .remaining_depth (remaining_depth),
        .score_in        (score_in),
        .bound_kind      (bound_kind),
        .best_move       (best_move),
        .window_low      (window_low),
        .window_high     (window_high),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .score_out       (score_out),
        .score_valid     (score_valid),
        .move_out        (move_out),
        .key_hit         (key_hit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Shift a mate score by the ply distance; dir +1 on record, -1 on probe
    function automatic int mate_shift(int s, int ply_gap, int dir);
        if (s > mate_limit)
            return clamp16(s + dir * ply_gap);
        if (s < -mate_limit)
            return clamp16(s - dir * ply_gap);
        return s;
    endfunction

    // Apply one word to the shadow store; return 1 with the answer for a probe
    function automatic bit table_access(input search_word_t w, output probe_result_t r);
        tt_pkg::entry_t e;
        int             slot;
        int             ply_gap;
        int             s;
        slot    = int'(w.key[IDX-1:0]);
        e       = shadow_table.exists(slot) ? shadow_table[slot] : '0;
        ply_gap = int'(w.root) - int'(w.rem);
        r       = '0;
        if (w.kind == tt_pkg::KIND_RECORD)
        begin
            s = mate_shift(int'($signed(w.score)), ply_gap, 1);
            if (w.rem >= e.depth)
            begin
                e.key   = w.key;
                e.score = s[15:0];
                e.depth = w.rem;
                e.flag  = w.bound;
                e.move  = w.move;
                shadow_table[slot] = e;
            end
            return 1'b0;
        end
        r.hit = (e.key == w.key);
        if (r.hit && e.depth >= w.rem)
        begin
            s = mate_shift(int'($signed(e.score)), ply_gap, -1);
            case (e.flag)
                tt_pkg::BOUND_EXACT:
                begin
                    r.valid = 1'b1;
                    r.score = s[15:0];
                end
                tt_pkg::BOUND_UPPER:
                    if (s <= int'($signed(w.alpha)))
                    begin
                        r.valid = 1'b1;
                        r.score = w.alpha;
                    end
                tt_pkg::BOUND_LOWER:
                    if (s >= int'($signed(w.beta)))
                    begin
                        r.valid = 1'b1;
                        r.score = w.beta;
                    end
                default: ;
            endcase
        end
        r.move = r.hit ? e.move : 16'h0000;
        return 1'b1;
    endfunction

    function automatic search_word_t make_word(logic k, logic [63:0] key, int root, int rem,
                                               int score, logic [1:0] bound, logic [15:0] move,
                                               int alpha, int beta);
        search_word_t w;
        w.kind  = k;
        w.key   = key;
        w.root  = root[7:0];
        w.rem   = rem[7:0];
        w.score = score[15:0];
        w.bound = bound;
        w.move  = move;
        w.alpha = alpha[15:0];
        w.beta  = beta[15:0];
        return w;
    endfunction

    // Favor scores around the mate threshold and the 16-bit extremes
    function automatic int pick_score(int thr);
        int          j;
        logic [15:0] raw;
        j   = $urandom_range(0, 4);
        raw = 16'($urandom);
        case ($urandom_range(0, 4))
            0: return clamp16(thr + j);
            1: return clamp16(-thr - j);
            2: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 300))
                                           : -32768 + int'($urandom_range(0, 300));
            default: return int'($signed(raw));
        endcase
    endfunction

    function automatic search_word_t make_search_word(int thr);
        search_word_t w;
        int           pick;
        int           rem_i;
        int           root_i;
        int           d;
        logic [15:0]  raw;
        w.kind = ($urandom_range(0, 99) < 55) ? tt_pkg::KIND_PROBE : tt_pkg::KIND_RECORD;
        pick   = $urandom_range(0, 99);
        if (pick < 85)
            w.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 95)
            w.key = {$urandom, $urandom};
        else
            w.key = '0;
        rem_i  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        root_i = $urandom_range(0, 1) ? rem_i + int'($urandom_range(0, 10))
                                      : int'($urandom_range(0, 255));
        if (root_i > 255)
            root_i = 255;
        w.rem   = rem_i[7:0];
        w.root  = root_i[7:0];
        w.score = 16'(pick_score(thr));
        w.bound = 2'($urandom_range(0, 3));
        w.move  = 16'($urandom);
        d       = $urandom_range(0, 6);
        raw     = 16'($urandom);
        w.alpha = $urandom_range(0, 1) ? 16'(clamp16(pick_score(thr) + d - 3)) : raw;
        d       = $urandom_range(0, 6);
        raw     = 16'($urandom);
        w.beta  = $urandom_range(0, 1) ? 16'(clamp16(pick_score(thr) + d - 3)) : raw;
        return w;
    endfunction

    task automatic write_mate_limit(int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[14:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        mate_limit = value;
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued word is taken and every probe answer is back
    task automatic wait_for_drain();
        @(posedge clk);
        while (pending_words.size() != 0 || in_valid || probe_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: predict the word taken at this edge, then offer the next one
    always @(posedge clk)
    begin : drive_words
        probe_result_t due;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (table_access(offered_word, due))
                    probe_results_due.push_back(due);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    offered_word <= pending_words.pop_front();
                    in_valid     <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off when asked, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_phase && !hold_done)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor: compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        probe_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (probe_results_due.size() == 0)
            begin
                $error("result word with no probe outstanding");
                mismatch_count++;
            end
            else
            begin
                want = probe_results_due.pop_front();
                if (score_out !== want.score)
                begin
                    $error("score_out: expected %0d, actual %0d", want.score, score_out);
                    mismatch_count++;
                end
                if (score_valid !== want.valid)
                begin
                    $error("score_valid: expected %0b, actual %0b", want.valid, score_valid);
                    mismatch_count++;
                end
                if (move_out !== want.move)
                begin
                    $error("move_out: expected %04h, actual %04h", want.move, move_out);
                    mismatch_count++;
                end
                if (key_hit !== want.hit)
                begin
                    $error("key_hit: expected %0b, actual %0b", want.hit, key_hit);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : run_phases
        int           thr_list [PHASES];
        int           thr;
        logic [IDX-1:0] index_set [8];
        logic [63:0]  ka;
        logic [63:0]  kb;
        logic [63:0]  kc;
        logic [63:0]  kd;
        logic [63:0]  ke;
        logic [63:0]  kf;
        logic [63:0]  kg;
        logic [63:0]  ka_alias;
        thr_list = '{0, 32767, 1000, 0, 30000, 5, 32767, 20000};
        ka       = 64'hA5A5_0000_1111_0010;
        ka_alias = 64'h5A5A_0000_1111_0010;
        kb       = 64'h0123_4567_89AB_0020;
        kc       = 64'h0F0F_F0F0_3C3C_0030;
        kd       = 64'h7777_8888_9999_0040;
        ke       = 64'h1357_9BDF_2468_0050;
        kf       = 64'hDEAD_0000_BEEF_0060;
        kg       = 64'hFFFF_FFFF_FFFF_FFFF;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at the reset threshold
        write_mate_limit(30000);
        // fresh store: key zero hits with exact zero, deeper probe gets no score
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, '0, 0, 0, 0,
                                          tt_pkg::BOUND_EXACT, 0, -32768, 32767));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, '0, 0, 5, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kg, 0, 0, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        // plain exact score, then too shallow, then same slot other key
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, ka, 10, 10, 100,
                                          tt_pkg::BOUND_EXACT, 16'h1234, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ka, 10, 10, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ka, 10, 11, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ka_alias, 10, 10, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        // mate score shifted on record, shifted back on probe, negative distance
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, kb, 10, 3, 31000,
                                          tt_pkg::BOUND_EXACT, 16'hFFFF, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kb, 10, 3, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kb, 0, 3, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        // saturation on record and on probe
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, kc, 255, 200, 32767,
                                          tt_pkg::BOUND_EXACT, 16'h00FF, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kc, 0, 200, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, kg, 255, 0, -32768,
                                          tt_pkg::BOUND_UPPER, 16'hFFFF, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kg, 255, 0, 0,
                                          tt_pkg::BOUND_EXACT, 0, 32767, -32768));
        // upper bound: usable only at or below alpha
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, kd, 5, 5, 50,
                                          tt_pkg::BOUND_UPPER, 16'h0001, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kd, 5, 5, 0,
                                          tt_pkg::BOUND_EXACT, 0, 60, 32767));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kd, 5, 5, 0,
                                          tt_pkg::BOUND_EXACT, 0, 40, -32768));
        // lower bound: usable only at or above beta
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, ke, 5, 5, 50,
                                          tt_pkg::BOUND_LOWER, 16'h8000, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ke, 5, 5, 0,
                                          tt_pkg::BOUND_EXACT, 0, -32768, 40));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ke, 5, 5, 0,
                                          tt_pkg::BOUND_EXACT, 0, 32767, 60));
        // bound code three never yields a score
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, kf, 5, 5, 7,
                                          2'd3, 16'hAAAA, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, kf, 5, 5, 0,
                                          tt_pkg::BOUND_EXACT, 0, 32767, -32768));
        // equal depth replaces, shallower does not, deeper other key evicts
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, ka, 10, 10, -7,
                                          tt_pkg::BOUND_EXACT, 16'h5555, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, ka, 10, 4, 9,
                                          tt_pkg::BOUND_EXACT, 16'h7777, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ka, 10, 4, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_RECORD, ka_alias, 30, 20, 3,
                                          tt_pkg::BOUND_EXACT, 16'h0F0F, 0, 0));
        pending_words.push_back(make_word(tt_pkg::KIND_PROBE, ka, 10, 4, 0,
                                          tt_pkg::BOUND_EXACT, 0, 0, 0));
        wait_for_drain();

        // Random phases
        for (int p = 0; p < PHASES; p++)
        begin
            thr = (p == 3) ? int'($urandom_range(0, 32767)) : thr_list[p];
            write_mate_limit(thr);
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 67; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 67; end
                default: begin sender_idle_pct = 11; stall_pct = 11; end
            endcase
            // fresh key pool: few slots, several keys per slot
            for (int i = 0; i < 8; i++)
                index_set[i] = IDX'($urandom);
            index_set[0] = '0;
            index_set[1] = '1;
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                key_pool[i]        = {$urandom, $urandom};
                key_pool[i][IDX-1:0] = index_set[i % 8];
            end
            if (p == 4)
                hold_phase = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (p == 5 && n == WORDS_PER_PHASE / 2)
                    wait_for_drain();
                pending_words.push_back(make_search_word(thr));
            end
            wait_for_drain();
        end

        if (probe_results_due.size() != 0)
            $error("%0d probe answers never arrived", probe_results_due.size());
        if (mismatch_count == 0 && probe_results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- transposition_table.f -----
rtl/tt_pkg.sv
rtl/tt_ctrl.sv
rtl/tt_datapath.sv
rtl/transposition_table.sv
rtl/tt_checker.sv
test/tb_transposition_table.sv
